// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the audio source/volume sequencer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASVS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASVS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/asvs_pkg.sv -----
// Package for the audio source/volume sequencer: source codes, config indexes,
// constants and the item/result/status structs. No dependencies.
`timescale 1ns / 1ps

package asvs_pkg;

  localparam logic [2:0] SRC_NONE    = 3'd0;
  localparam logic [2:0] SRC_RADIO   = 3'd1;
  localparam logic [2:0] SRC_HOST    = 3'd2;
  localparam logic [2:0] SRC_CALLMOD = 3'd3;
  localparam logic [2:0] SRC_DISC    = 3'd4;
  localparam logic [2:0] SRC_AUX     = 3'd5;
  localparam logic [2:0] SRC_TV      = 3'd6;
  localparam logic [2:0] SRC_INVALID = 3'd7;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_CALL_PATH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_PERCENT = 1'd1;

  localparam logic [6:0] PCT_FULL      = 7'd100;
  localparam logic [6:0] REV_PCT_RESET = 7'd50;

  // x / 100 == (x * 5243) >> 19 for x below 43690
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  localparam int GATE_HOST_ON    = 0;
  localparam int GATE_DISC_READY = 1;
  localparam int GATE_RADIO_MUTE = 2;
  localparam int GATE_REVERSE    = 3;

  typedef struct packed {
    logic [2:0]  requested_source;
    logic        phone_on;
    logic        projected_phone_call;
    logic        voice_assist_on;
    logic        standby;
    logic        traffic_announce;
    logic        app_interrupt;
    logic [3:0]  gate_flags;
    logic [7:0]  main_volume;
    logic [7:0]  call_volume;
    logic [7:0]  assist_volume;
    logic [14:0] rev_product;
  } item_t;

  typedef struct packed {
    logic [2:0] active_source;
    logic       source_update;
    logic [7:0] volume_level;
    logic       volume_update;
    logic       unmute_request;
    logic       switch_pending;
  } res_t;

  typedef struct packed {
    logic [2:0] routed_src;
    logic [7:0] cur_volume;
    logic [7:0] hold_count;
    logic       ramping;
  } status_t;

endpackage

// ----- rtl/asvs_if.sv -----
// Handshake interfaces for the sequencer: request items, result items, config writes.
// Depends on asvs_pkg.
`timescale 1ns / 1ps

interface asvs_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] requested_source;
  logic       phone_on;
  logic       projected_phone_call;
  logic       voice_assist_on;
  logic       standby;
  logic       traffic_announce;
  logic       app_interrupt;
  logic [3:0] gate_flags;
  logic [7:0] main_volume;
  logic [7:0] call_volume;
  logic [7:0] assist_volume;

  modport source (
    output valid, requested_source, phone_on, projected_phone_call, voice_assist_on,
           standby, traffic_announce, app_interrupt, gate_flags, main_volume,
           call_volume, assist_volume,
    input  ready
  );
  modport sink (
    input  valid, requested_source, phone_on, projected_phone_call, voice_assist_on,
           standby, traffic_announce, app_interrupt, gate_flags, main_volume,
           call_volume, assist_volume,
    output ready
  );
endinterface

interface asvs_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] active_source;
  logic       source_update;
  logic [7:0] volume_level;
  logic       volume_update;
  logic       unmute_request;
  logic       switch_pending;

  modport source (
    output valid, active_source, source_update, volume_level, volume_update,
           unmute_request, switch_pending,
    input  ready
  );
  modport sink (
    input  valid, active_source, source_update, volume_level, volume_update,
           unmute_request, switch_pending,
    output ready
  );
endinterface

interface asvs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [asvs_pkg::CFG_IDX_W-1:0]  index;
  logic [asvs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/asvs_in_stage.sv -----
// Input register of the sequencer: captures one request item and the reverse product.
// Depends on asvs_pkg and asvs_if.
`timescale 1ns / 1ps

module asvs_in_stage (
  input  logic            clk,
  input  logic            rst,
  asvs_req_if.sink        req_ch,
  input  logic [6:0]      rev_pct,
  input  logic            fire,
  output logic            valid,
  output asvs_pkg::item_t item
);

  logic load;

  assign req_ch.ready = !valid || fire;
  assign load         = req_ch.valid && req_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (fire) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.requested_source     <= req_ch.requested_source;
      item.phone_on             <= req_ch.phone_on;
      item.projected_phone_call <= req_ch.projected_phone_call;
      item.voice_assist_on      <= req_ch.voice_assist_on;
      item.standby              <= req_ch.standby;
      item.traffic_announce     <= req_ch.traffic_announce;
      item.app_interrupt        <= req_ch.app_interrupt;
      item.gate_flags           <= req_ch.gate_flags;
      item.main_volume          <= req_ch.main_volume;
      item.call_volume          <= req_ch.call_volume;
      item.assist_volume        <= req_ch.assist_volume;
      item.rev_product          <= 15'(req_ch.main_volume) * 15'(rev_pct);
    end
  end

endmodule

// ----- rtl/asvs_seq.sv -----
// Sequencer state and per-item step: source priority, hold counter, switch phase, ramp.
// Depends on asvs_pkg.
`timescale 1ns / 1ps

module asvs_seq #(
  parameter logic [7:0] HOLD_TICKS = 8'd25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  asvs_pkg::item_t   item,
  input  logic              host_call_path,
  output asvs_pkg::res_t    res,
  output asvs_pkg::status_t st
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RAMP  = 2'd1,
    PH_READY = 2'd2
  } phase_t;

  phase_t     phase, phase_next;
  logic [2:0] routed_src, routed_src_next;
  logic [7:0] cur_volume, cur_volume_next;
  logic [7:0] hold_count, hold_count_next;
  logic       last_phone;

  logic [2:0]  req_src, src;
  logic [7:0]  hold, target, step;
  logic [27:0] scaled;
  logic        src_upd, vol_upd;

  assign scaled = 28'(item.rev_product) * 28'(asvs_pkg::RECIP_100);

  always_comb begin
    phase_next      = phase;
    routed_src_next = routed_src;
    cur_volume_next = cur_volume;
    src_upd         = 1'b0;
    vol_upd         = 1'b0;

    req_src = (item.requested_source == asvs_pkg::SRC_INVALID) ? asvs_pkg::SRC_NONE
                                                               : item.requested_source;
    hold = (item.phone_on != last_phone) ? HOLD_TICKS : hold_count;

    if (item.phone_on) begin
      src = (item.projected_phone_call || host_call_path) ? asvs_pkg::SRC_HOST
                                                          : asvs_pkg::SRC_CALLMOD;
    end else if (item.voice_assist_on) begin
      src = asvs_pkg::SRC_CALLMOD;
    end else if (item.standby) begin
      src = asvs_pkg::SRC_NONE;
    end else if (item.traffic_announce) begin
      src = asvs_pkg::SRC_RADIO;
    end else if (item.app_interrupt) begin
      src = asvs_pkg::SRC_HOST;
    end else begin
      src = req_src;
    end

    hold_count_next = hold;
    if (hold != 8'd0) begin
      hold_count_next = hold - 8'd1;
      src             = asvs_pkg::SRC_NONE;
    end
    if (src == asvs_pkg::SRC_RADIO && item.gate_flags[asvs_pkg::GATE_RADIO_MUTE]) begin
      src = asvs_pkg::SRC_NONE;
    end
    if (src == asvs_pkg::SRC_DISC && !item.gate_flags[asvs_pkg::GATE_DISC_READY]) begin
      phase_next = PH_READY;
      src        = asvs_pkg::SRC_NONE;
    end
    if (src == asvs_pkg::SRC_HOST && !item.gate_flags[asvs_pkg::GATE_HOST_ON]) begin
      src = asvs_pkg::SRC_NONE;
    end

    if (src != routed_src) begin
      routed_src_next = src;
      phase_next      = item.app_interrupt ? PH_READY : PH_RAMP;
    end
    if (phase_next == PH_READY) begin
      src_upd    = 1'b1;
      phase_next = PH_IDLE;
    end

    if (item.phone_on) begin
      target = item.call_volume;
    end else if (item.voice_assist_on) begin
      target = item.assist_volume;
    end else if (item.gate_flags[asvs_pkg::GATE_REVERSE]) begin
      target = scaled[asvs_pkg::RECIP_SHIFT+7:asvs_pkg::RECIP_SHIFT];
    end else begin
      target = item.main_volume;
    end
    if (phase_next == PH_RAMP) begin
      target = 8'd0;
    end

    if (cur_volume < target) begin
      step = cur_volume + 8'd1;
    end else if (cur_volume > target) begin
      step = cur_volume - 8'd1;
    end else begin
      step = cur_volume;
    end

    if (step != cur_volume) begin
      cur_volume_next = step;
      vol_upd         = 1'b1;
    end else if (phase_next == PH_RAMP) begin
      phase_next = PH_READY;
    end

    res.active_source  = routed_src_next;
    res.source_update  = src_upd;
    res.volume_level   = cur_volume_next;
    res.volume_update  = vol_upd;
    res.unmute_request = (src != asvs_pkg::SRC_NONE);
    res.switch_pending = (phase_next == PH_RAMP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      routed_src <= asvs_pkg::SRC_NONE;
      cur_volume <= 8'd0;
      hold_count <= 8'd0;
      last_phone <= 1'b0;
    end else if (fire) begin
      phase      <= phase_next;
      routed_src <= routed_src_next;
      cur_volume <= cur_volume_next;
      hold_count <= hold_count_next;
      last_phone <= item.phone_on;
    end
  end

  assign st.routed_src = routed_src;
  assign st.cur_volume = cur_volume;
  assign st.hold_count = hold_count;
  assign st.ramping    = (phase == PH_RAMP);

endmodule

// ----- rtl/asvs_out_stage.sv -----
// Result register of the sequencer: holds one result item until the receiver takes it.
// Depends on asvs_pkg and asvs_if.
`timescale 1ns / 1ps

module asvs_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  asvs_pkg::res_t res,
  asvs_res_if.source     res_ch,
  output logic           free
);

  logic           valid;
  asvs_pkg::res_t data;

  assign free = !valid || res_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (fire) begin
      valid <= 1'b1;
    end else if (res_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      data <= res;
    end
  end

  assign res_ch.valid          = valid;
  assign res_ch.active_source  = data.active_source;
  assign res_ch.source_update  = data.source_update;
  assign res_ch.volume_level   = data.volume_level;
  assign res_ch.volume_update  = data.volume_update;
  assign res_ch.unmute_request = data.unmute_request;
  assign res_ch.switch_pending = data.switch_pending;

endmodule

// ----- rtl/audio_source_volume_sequencer_core.sv -----
// Audio source/volume sequencer, top level: config registers, input register,
// step logic and result register. Depends on asvs_pkg, asvs_if and the asvs_* modules.
//
// Usage:
//   req_ch carries one control tick per item: requested source, call/assist/standby/
//   interrupt flags, gate flags and three volumes. res_ch returns exactly one result
//   item per request item, in order: routed source, source strobe, ramped volume,
//   volume strobe, unmute request and the ramp-down flag.
//   cfg writes host_call_path (index 0) and reverse_percent (index 1); it is always
//   ready. The user must write it only while no item is in flight; the block does
//   not enforce this. An accepted item waits in the input register; when the
//   result register is free, the step logic runs, updates the state and loads the
//   result register, which raises res_ch.valid. Throughput is one item per cycle
//   while res_ch.ready stays high; the state and result registers load in the same cycle.
//   A stalled receiver holds the result register; one more item can wait in the input
//   register, after which req_ch.ready drops until res_ch.ready returns.
//   Reset (rst, synchronous) empties both registers, sets source none, volume 0,
//   hold counter 0, switch phase idle, host_call_path 0 and reverse_percent 50.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module audio_source_volume_sequencer_core #(
  parameter int unsigned HOLD_TICKS = 25
) (
  input  logic       clk,
  input  logic       rst,
  asvs_req_if.sink   req_ch,
  asvs_res_if.source res_ch,
  asvs_cfg_if.sink   cfg
);

  logic              host_call_path;
  logic [6:0]        reverse_percent;
  logic [6:0]        rev_pct;
  logic              in_valid;
  logic              out_free;
  logic              fire;
  asvs_pkg::item_t   item;
  asvs_pkg::res_t    res;
  asvs_pkg::status_t st;
  logic [7:0]        vol;
  logic              in_hold;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      host_call_path  <= 1'b0;
      reverse_percent <= asvs_pkg::REV_PCT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        asvs_pkg::CFG_HOST_CALL_PATH:  host_call_path  <= cfg.data[0];
        asvs_pkg::CFG_REVERSE_PERCENT: reverse_percent <= cfg.data[6:0];
        default: ;
      endcase
    end
  end

  assign rev_pct = (reverse_percent > asvs_pkg::PCT_FULL) ? asvs_pkg::PCT_FULL
                                                          : reverse_percent;
  assign fire    = in_valid && out_free;

  asvs_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .req_ch  (req_ch),
    .rev_pct (rev_pct),
    .fire    (fire),
    .valid   (in_valid),
    .item    (item)
  );

  asvs_seq #(
    .HOLD_TICKS (8'(HOLD_TICKS))
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .item           (item),
    .host_call_path (host_call_path),
    .res            (res),
    .st             (st)
  );

  asvs_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .res    (res),
    .res_ch (res_ch),
    .free   (out_free)
  );

  assign vol     = st.cur_volume;
  assign in_hold = fire && (st.hold_count != 8'd0);

  `ASVS_ASSERT_NXT(a_state_hold, clk, rst, !fire, $stable(st), "state moved without an item")
  `ASVS_ASSERT_NXT(a_vol_step, clk, rst, fire, vol - $past(vol) + 8'd1 < 8'd3, "volume jump")
  `ASVS_ASSERT_IMP(a_hold_mute, clk, rst, in_hold, !res.unmute_request, "unmute in hold")

endmodule
